>>> rtl/info_frame_receiver_destuff_check_top_macros.svh
// Assertion macros shared by the receiver RTL.
`ifndef INFO_FRAME_RECEIVER_DESTUFF_CHECK_TOP_MACROS_SVH
`define INFO_FRAME_RECEIVER_DESTUFF_CHECK_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising edge and silent during reset.
`define IFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge and silent during reset.
`define IFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ifrdc_pkg.sv
package ifrdc_pkg;

  localparam int unsigned MAX_FRAME = 4096;
  localparam logic [11:0] RAW_CAP   = 12'(MAX_FRAME - 1);

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_LINK_ADDRESS = 2'd0,
    REG_CTRL_SEQ0    = 2'd1,
    REG_CTRL_SEQ1    = 2'd2,
    REG_MAX_RAW_LEN  = 2'd3
  } reg_index_t;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_FLAG = 5'b00010,
    PH_ADDR = 5'b00100,
    PH_CTRL = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [11:0] len;
    logic        seq;
  } result_t;

endpackage

>>> rtl/info_frame_receiver_destuff_check_top.sv
// Byte-stuffed information-frame receiver. Each input word carries one raw byte from the
// serial line (req_type 0) or a timeout abort (req_type 1). The block hunts for the flag
// 0x7E, checks the address, the control byte that matches the expected sequence bit and
// the header check byte (address XOR control), and then destuffs the body: 0x7D escapes
// the next byte, which is XORed with 0x20. Each destuffed byte leaves as a payload word
// one byte late, so that the last body byte is held back as the body check byte. At the
// closing flag a single accept or reject word gives the payload length and the sequence
// bit for the reply; an accept toggles the expected sequence bit. Empty frames and a
// closing flag straight after an escape are rejected, a body that would run past the raw
// length limit is dropped silently, and a timeout or a header mismatch returns to hunting
// with no output, but a flag in place of a header byte opens a new frame. The block takes
// one byte per clock cycle while input stall is low: the whole decision for a byte is made
// in a single pass of logic from the frame state registers into the output register, or
// into the skid register while that register waits, so this two-entry output stage can
// take a byte while an earlier result waits; input stall rises only when both are full.
// Configuration writes are always ready and should be made only while the block is idle.
module info_frame_receiver_destuff_check_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output ifrdc_pkg::kind_t    result_kind,
  output logic [7:0]          payload_byte,
  output logic [11:0]         payload_len,
  output logic                reply_seq,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data
);
  import ifrdc_pkg::*;

  // Configuration registers.
  logic [7:0]  link_address;
  logic [7:0]  ctrl_seq0;
  logic [7:0]  ctrl_seq1;
  logic [11:0] max_raw_len;

  // Frame state.
  phase_t      phase, phase_next;
  logic        expected_seq, expected_seq_next;
  logic        escape_pending, escape_pending_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        held_valid, held_valid_next;
  logic [7:0]  parity_acc, parity_acc_next;
  logic [11:0] raw_count, raw_count_next;
  logic [11:0] payload_count, payload_count_next;

  // Output stage.
  result_t     out_word;
  result_t     skid_word;
  logic        skid_valid;

  logic        in_fire;
  logic        out_fire;
  logic        res_valid;
  result_t     res;
  logic [7:0]  ctrl_expected;
  logic [11:0] raw_limit;
  logic [7:0]  body_byte;
  logic        frame_ok;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  assign result_kind  = out_word.kind;
  assign payload_byte = out_word.data;
  assign payload_len  = out_word.len;
  assign reply_seq    = out_word.seq;

  assign ctrl_expected = expected_seq ? ctrl_seq1 : ctrl_seq0;
  assign raw_limit     = (max_raw_len < RAW_CAP) ? max_raw_len : RAW_CAP;
  // An escaped byte is restored here; a byte that is itself the escape is not pushed.
  assign body_byte     = escape_pending ? (rx_byte ^ ESC_XOR) : rx_byte;
  assign frame_ok      = held_valid && !escape_pending && (parity_acc == held_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      link_address <= 8'd3;
      ctrl_seq0    <= 8'h00;
      ctrl_seq1    <= 8'h40;
      max_raw_len  <= 12'd4095;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_LINK_ADDRESS: link_address <= cfg_data[7:0];
        REG_CTRL_SEQ0:    ctrl_seq0    <= cfg_data[7:0];
        REG_CTRL_SEQ1:    ctrl_seq1    <= cfg_data[7:0];
        REG_MAX_RAW_LEN:  max_raw_len  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Single-pass decision for one accepted byte.
  always_comb begin
    phase_next          = phase;
    expected_seq_next   = expected_seq;
    escape_pending_next = escape_pending;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    parity_acc_next     = parity_acc;
    raw_count_next      = raw_count;
    payload_count_next  = payload_count;
    res_valid           = 1'b0;
    res                 = '{kind: KIND_BYTE, data: 8'd0, len: 12'd0, seq: 1'b0};

    // A timeout drops the frame at once and returns to hunting.
    if (req_type) begin
      phase_next          = PH_HUNT;
      raw_count_next      = 12'd0;
      escape_pending_next = 1'b0;
      held_byte_next      = 8'd0;
      held_valid_next     = 1'b0;
      parity_acc_next     = 8'd0;
      payload_count_next  = 12'd0;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == FLAG_BYTE) begin
            phase_next     = PH_FLAG;
            raw_count_next = 12'd1;
          end
        end
        PH_FLAG: begin
          if (rx_byte == link_address) begin
            phase_next     = PH_ADDR;
            raw_count_next = 12'd2;
          end else if (rx_byte == FLAG_BYTE) begin
            raw_count_next = 12'd1;
          end else begin
            phase_next     = PH_HUNT;
            raw_count_next = 12'd0;
          end
        end
        PH_ADDR: begin
          if (rx_byte == ctrl_expected) begin
            phase_next     = PH_CTRL;
            raw_count_next = 12'd3;
          end else if (rx_byte == FLAG_BYTE) begin
            phase_next     = PH_FLAG;
            raw_count_next = 12'd1;
          end else begin
            phase_next     = PH_HUNT;
            raw_count_next = 12'd0;
          end
        end
        PH_CTRL: begin
          if (rx_byte == (link_address ^ ctrl_expected)) begin
            phase_next          = PH_DATA;
            raw_count_next      = 12'd4;
            escape_pending_next = 1'b0;
            held_byte_next      = 8'd0;
            held_valid_next     = 1'b0;
            parity_acc_next     = 8'd0;
            payload_count_next  = 12'd0;
          end else if (rx_byte == FLAG_BYTE) begin
            phase_next     = PH_FLAG;
            raw_count_next = 12'd1;
          end else begin
            phase_next     = PH_HUNT;
            raw_count_next = 12'd0;
          end
        end
        PH_DATA: begin
          if (rx_byte == FLAG_BYTE || raw_count >= raw_limit) begin
            // Closing flag or overlong frame: the frame ends either way.
            phase_next          = PH_HUNT;
            raw_count_next      = 12'd0;
            escape_pending_next = 1'b0;
            held_byte_next      = 8'd0;
            held_valid_next     = 1'b0;
            parity_acc_next     = 8'd0;
            payload_count_next  = 12'd0;
            if (rx_byte == FLAG_BYTE) begin
              expected_seq_next = expected_seq ^ frame_ok;
              res_valid         = 1'b1;
              res.kind          = frame_ok ? KIND_ACCEPT : KIND_REJECT;
              res.len           = payload_count;
              res.seq           = expected_seq ^ frame_ok;
            end
          end else begin
            raw_count_next = raw_count + 12'd1;
            if (!escape_pending && rx_byte == ESC_BYTE) begin
              escape_pending_next = 1'b1;
            end else begin
              escape_pending_next = 1'b0;
              held_byte_next      = body_byte;
              held_valid_next     = 1'b1;
              if (held_valid) begin
                parity_acc_next    = parity_acc ^ held_byte;
                payload_count_next = payload_count + 12'd1;
                res_valid          = 1'b1;
                res.data           = held_byte;
              end
            end
          end
        end
        default: begin
          phase_next          = PH_HUNT;
          raw_count_next      = 12'd0;
          escape_pending_next = 1'b0;
          held_byte_next      = 8'd0;
          held_valid_next     = 1'b0;
          parity_acc_next     = 8'd0;
          payload_count_next  = 12'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      expected_seq   <= 1'b0;
      escape_pending <= 1'b0;
      held_byte      <= 8'd0;
      held_valid     <= 1'b0;
      parity_acc     <= 8'd0;
      raw_count      <= 12'd0;
      payload_count  <= 12'd0;
    end else if (in_fire) begin
      phase          <= phase_next;
      expected_seq   <= expected_seq_next;
      escape_pending <= escape_pending_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
      parity_acc     <= parity_acc_next;
      raw_count      <= raw_count_next;
      payload_count  <= payload_count_next;
    end
  end

  // Output register with a skid entry behind it. A new result goes to the output register
  // when that register is empty or being drained, and to the skid entry otherwise. The skid
  // entry moves forward as soon as the output register drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_fire) begin
          skid_valid <= 1'b0;
        end
      end else if (in_fire && res_valid) begin
        if (out_valid && out_stall) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_word <= skid_word;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid && out_stall) begin
        skid_word <= res;
      end else begin
        out_word <= res;
      end
    end
  end

`include "info_frame_receiver_destuff_check_top_macros.svh"

  `IFR_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
                  "skid entry full with output empty")
  `IFR_ASSERT_NEXT(a_result_to_skid,
                   in_fire && res_valid && out_valid && out_stall && !skid_valid,
                   skid_valid, "result lost while output stalled")
  `IFR_ASSERT_NOW(a_body_clear_outside, phase != PH_DATA,
                  !held_valid && payload_count == 12'd0 && !escape_pending,
                  "body state left over outside a frame")
  `IFR_ASSERT_NEXT(a_seq_only_on_accept,
                   !(in_fire && res_valid && res.kind == KIND_ACCEPT),
                   $stable(expected_seq), "sequence bit changed without an accept")

endmodule
